### rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // End-of-string status codes
   localparam logic [2:0] StatusOk    = 3'd0;
   localparam logic [2:0] StatusFrame = 3'd1;
   localparam logic [2:0] StatusCtrl  = 3'd2;
   localparam logic [2:0] StatusEsc   = 3'd3;
   localparam logic [2:0] StatusHex   = 3'd4;
   localparam logic [2:0] StatusSurr  = 3'd5;
   localparam logic [2:0] StatusTrunc = 3'd6;

   // Work queue between the decoder and the emitter
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam int CpW = 21;

   // One unit of output work: a code point to encode, or an end status
   typedef struct packed {
      logic           is_end;
      logic [2:0]     status;
      logic [1:0]     len_m1;   // number of output bytes minus one
      logic [CpW-1:0] cp;       // code point, or raw byte in the low bits
   } task_type;

   // Output byte count minus one for a code point
   function automatic logic [1:0] utf8_len_m1(input logic [CpW-1:0] cp);
      logic [1:0] len;
      if (cp[CpW-1:7] == '0) begin
         len = 2'd0;
      end else if (cp[CpW-1:11] == '0) begin
         len = 2'd1;
      end else if (cp[CpW-1:16] == '0) begin
         len = 2'd2;
      end else begin
         len = 2'd3;
      end
      return len;
   endfunction

endpackage

### rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Decoder: tracks framing and escape state, taking one request byte per cycle
// unless the work queue is full, and posts code points and end statuses there.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_first_of_string,
   input  logic               req_last_of_string,
   input  logic               q_full,
   output logic               q_push,
   output jsu_pkg::task_type  q_task
);

   localparam logic [2:0] PhIdle  = 3'd0;
   localparam logic [2:0] PhEsc   = 3'd1;
   localparam logic [2:0] PhHex1  = 3'd2;
   localparam logic [2:0] PhLowBs = 3'd3;
   localparam logic [2:0] PhLowU  = 3'd4;
   localparam logic [2:0] PhHex2  = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  digits_ff, digits_in;
   logic [9:0]  hs_ff, hs_in;
   logic [2:0]  err_ff, err_in;
   logic        opened_ff, opened_in;

   logic        accept;
   logic [7:0]  b;
   logic [4:0]  hex_d;       // bit 4 flags a non-hex byte
   logic [15:0] acc_next;
   logic [2:0]  digits_next;
   logic        esc_ok;
   logic [7:0]  esc_val;
   logic [2:0]  end_status;
   logic [jsu_pkg::CpW-1:0] push_cp;
   logic        push_raw;    // raw content byte, passed through as one byte

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_in_byte;

   // Decode hex digit
   always_comb begin
      if (b >= 8'h30 && b <= 8'h39) begin
         hex_d = {1'b0, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         hex_d = {1'b0, b[3:0] + 4'd9};
      end else begin
         hex_d = 5'h10;
      end
   end

   assign acc_next    = {acc_ff[11:0], hex_d[3:0]};
   assign digits_next = digits_ff - 3'd1;

   // Map single-character escapes
   always_comb begin
      esc_ok  = 1'b1;
      esc_val = b;
      unique case (b)
         8'h22, 8'h5C, 8'h2F: esc_val = b;
         8'h62: esc_val = 8'h08;
         8'h66: esc_val = 8'h0C;
         8'h6E: esc_val = 8'h0A;
         8'h72: esc_val = 8'h0D;
         8'h74: esc_val = 8'h09;
         default: esc_ok = 1'b0;
      endcase
   end

   // Pick the closing status, framing first
   always_comb begin
      if (!opened_ff || b != 8'h22) begin
         end_status = jsu_pkg::StatusFrame;
      end else if (err_ff != jsu_pkg::StatusOk) begin
         end_status = err_ff;
      end else if (phase_ff != PhIdle) begin
         end_status = jsu_pkg::StatusTrunc;
      end else begin
         end_status = jsu_pkg::StatusOk;
      end
   end

   // Advance the escape state machine
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      hs_in     = hs_ff;
      err_in    = err_ff;
      opened_in = opened_ff;
      q_push    = 1'b0;
      push_cp   = '0;
      push_raw  = 1'b0;
      q_task    = '0;

      if (accept) begin
         if (req_first_of_string) begin
            phase_in  = PhIdle;
            acc_in    = '0;
            digits_in = '0;
            hs_in     = '0;
            err_in    = jsu_pkg::StatusOk;
            opened_in = (b == 8'h22) && !req_last_of_string;
            if (req_last_of_string) begin
               q_push        = 1'b1;
               q_task.is_end = 1'b1;
               q_task.status = jsu_pkg::StatusFrame;
            end
         end else if (req_last_of_string) begin
            q_push        = 1'b1;
            q_task.is_end = 1'b1;
            q_task.status = end_status;
            phase_in      = PhIdle;
            acc_in        = '0;
            digits_in     = '0;
            hs_in         = '0;
            err_in        = jsu_pkg::StatusOk;
            opened_in     = 1'b0;
         end else if (opened_ff && err_ff == jsu_pkg::StatusOk) begin
            unique case (phase_ff)
               PhEsc: begin
                  if (b == 8'h75) begin
                     phase_in  = PhHex1;
                     acc_in    = '0;
                     digits_in = 3'd4;
                  end else if (esc_ok) begin
                     phase_in = PhIdle;
                     q_push   = 1'b1;
                     push_cp  = {13'd0, esc_val};
                  end else begin
                     err_in    = jsu_pkg::StatusEsc;
                     phase_in  = PhIdle;
                     digits_in = '0;
                  end
               end
               PhHex1, PhHex2: begin
                  if (hex_d[4]) begin
                     err_in    = jsu_pkg::StatusHex;
                     phase_in  = PhIdle;
                     digits_in = '0;
                  end else begin
                     acc_in    = acc_next;
                     digits_in = digits_next;
                     if (digits_next == 3'd0) begin
                        if (phase_ff == PhHex1) begin
                           if (acc_next[15:10] == 6'b110110) begin
                              hs_in    = acc_next[9:0];
                              phase_in = PhLowBs;
                           end else if (acc_next[15:10] == 6'b110111) begin
                              err_in   = jsu_pkg::StatusSurr;
                              phase_in = PhIdle;
                           end else begin
                              phase_in = PhIdle;
                              q_push   = 1'b1;
                              push_cp  = {5'd0, acc_next};
                           end
                        end else begin
                           if (acc_next[15:10] != 6'b110111) begin
                              err_in   = jsu_pkg::StatusSurr;
                              phase_in = PhIdle;
                           end else begin
                              phase_in = PhIdle;
                              q_push   = 1'b1;
                              push_cp  = 21'h10000 + {1'b0, hs_ff, acc_next[9:0]};
                           end
                        end
                     end
                  end
               end
               PhLowBs: begin
                  if (b != 8'h5C) begin
                     err_in    = jsu_pkg::StatusSurr;
                     phase_in  = PhIdle;
                     digits_in = '0;
                  end else begin
                     phase_in = PhLowU;
                  end
               end
               PhLowU: begin
                  if (b != 8'h75) begin
                     err_in    = jsu_pkg::StatusSurr;
                     phase_in  = PhIdle;
                     digits_in = '0;
                  end else begin
                     phase_in  = PhHex2;
                     acc_in    = '0;
                     digits_in = 3'd4;
                  end
               end
               default: begin
                  phase_in = PhIdle;
                  if (b < 8'h20 || b == 8'h22) begin
                     err_in    = jsu_pkg::StatusCtrl;
                     digits_in = '0;
                  end else if (b == 8'h5C) begin
                     phase_in = PhEsc;
                  end else begin
                     q_push   = 1'b1;
                     push_raw = 1'b1;
                     push_cp  = {13'd0, b};
                  end
               end
            endcase
            // Raw bytes pass through as one byte; code points get UTF-8 length
            if (q_push) begin
               q_task.cp     = push_cp;
               q_task.len_m1 = push_raw ? 2'd0 : jsu_pkg::utf8_len_m1(push_cp);
            end
         end
      end
   end

   // Hold per-string state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhIdle;
         acc_ff    <= '0;
         digits_ff <= '0;
         hs_ff     <= '0;
         err_ff    <= jsu_pkg::StatusOk;
         opened_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         hs_ff     <= hs_in;
         err_ff    <= err_in;
         opened_ff <= opened_in;
      end
   end

`ifndef SYNTH
   a_hex_digits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhHex1 || phase_ff == PhHex2) |-> digits_ff != 3'd0)
      else $error("hex phase with no digits left");
   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      (err_ff != jsu_pkg::StatusOk) |-> phase_ff == PhIdle)
      else $error("escape in progress after error");
   a_no_data_after_err: assert property (@(posedge clock) disable iff (reset)
      (q_push && !req_first_of_string && !req_last_of_string)
         |-> (opened_ff && err_ff == jsu_pkg::StatusOk))
      else $error("data posted outside a valid string");
`endif

endmodule

### rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short FIFO of decoded work between the decoder and the emitter.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jsu_pkg::task_type  push_task,
   input  logic               pop,
   output jsu_pkg::task_type  head_task,
   output logic               empty,
   output logic               full
);

   jsu_pkg::task_type entry_ff [jsu_pkg::QueueDepth];

   logic [jsu_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QueueCntW-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == jsu_pkg::QueueCntW'(jsu_pkg::QueueDepth));
   assign head_task = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed work
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_task;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && !full) |->
         (wr_ptr_ff != rd_ptr_ff))
      else $error("pointers disagree with occupancy");
`endif

endmodule

### rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Emitter: expands queued work into UTF-8 bytes and end results, one per
// cycle when not stalled by rsp_ready, through a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::task_type  head_task,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_end_of_string,
   output logic [2:0]         rsp_status_code,
   output logic               rsp_last_of_run
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic [2:0] status_ff;
   logic       last_ff;

   logic       out_load;
   logic       emit;
   logic       is_last;
   logic [1:0] grp;
   logic [5:0] cont_bits;
   logic [7:0] lead_byte;
   logic [7:0] cur_byte;

   assign out_load = !valid_ff || rsp_ready;
   assign emit     = out_load && !q_empty;
   assign is_last  = (idx_ff == head_task.len_m1);
   assign q_pop    = emit && is_last;
   assign grp      = head_task.len_m1 - idx_ff;

   // Select the continuation group
   always_comb begin
      case (grp)
         2'd0:    cont_bits = head_task.cp[5:0];
         2'd1:    cont_bits = head_task.cp[11:6];
         default: cont_bits = head_task.cp[17:12];
      endcase
   end

   // Build the lead byte
   always_comb begin
      case (head_task.len_m1)
         2'd0:    lead_byte = head_task.cp[7:0];
         2'd1:    lead_byte = {3'b110, head_task.cp[10:6]};
         2'd2:    lead_byte = {4'b1110, head_task.cp[15:12]};
         default: lead_byte = {5'b11110, head_task.cp[20:18]};
      endcase
   end

   assign cur_byte = (idx_ff == 2'd0) ? lead_byte : {2'b10, cont_bits};

   // Advance byte index and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (emit) begin
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff   <= cur_byte;
         end_ff    <= head_task.is_end;
         status_ff <= head_task.status;
         last_ff   <= is_last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_end_of_string = end_ff;
   assign rsp_status_code   = status_ff;
   assign rsp_last_of_run   = last_ff;

`ifndef SYNTH
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> idx_ff <= head_task.len_m1)
      else $error("byte index past code point length");
   a_mid_run_head: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> !q_empty)
      else $error("partial run with no queued work");
   a_end_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && end_ff) |-> (last_ff && byte_ff == 8'h00))
      else $error("malformed end result");
`endif

endmodule

### rtl/core/json_string_unescape_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Streaming JSON string unescaper: decodes escapes, joins surrogate pairs,
// emits UTF-8 bytes and one end result with a status per string.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_ready  | byte, first and last marks
//   rsp      | out       | rsp_valid/rsp_ready  | byte, end mark, status, run end
//
// The decoder takes one request byte per cycle while the queue has room; each
// byte posts at most one work entry to a four-deep queue. The emitter drains
// one byte per cycle unless rsp_ready stalls; each entry pops on its last byte.
// req_ready drops only when the queue is full; the output register holds a
// result until rsp_ready. Synchronous reset clears string state, the queue
// and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_string_unescape_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_string,
   output logic [2:0] rsp_status_code,
   output logic       rsp_last_of_run
);

   jsu_pkg::task_type push_task;
   jsu_pkg::task_type head_task;
   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   logic              q_full;

   jsu_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_task              (push_task)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_task (push_task),
      .pop       (q_pop),
      .head_task (head_task),
      .empty     (q_empty),
      .full      (q_full)
   );

   jsu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_task         (head_task),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_status_code   (rsp_status_code),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
